[sv/ptmu_pkg.sv]
// Package for the page table map/unmap engine: field widths, request and
// status codes, controller states and the memory command struct.
// No dependencies.
package ptmu_pkg;

  localparam int PAGE_W   = 14;
  localparam int PHYS_W   = 32;
  localparam int FLAGS_W  = 12;
  localparam int STATUS_W = 2;

  localparam logic [PHYS_W-1:0] ENTRY_PRESENT = 32'h0000_0001;

  typedef enum logic {
    REQ_MAP   = 1'b0,
    REQ_UNMAP = 1'b1
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_UNMAPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CS_INIT,
    CS_IDLE,
    CS_SPLIT,
    CS_CHECK,
    CS_CLEAR,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic dir_re;
    logic dir_we;
    logic dir_wbit;
    logic ent_re;
    logic ent_we;
  } mem_cmd_t;

endpackage

[sv/ptmu_req_if.sv]
// Request channel of the page table map/unmap engine.
// Depends on ptmu_pkg for the field widths.
interface ptmu_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ptmu_pkg::PAGE_W-1:0]  virt_page;
  logic [ptmu_pkg::PHYS_W-1:0]  phys_addr;
  logic [ptmu_pkg::FLAGS_W-1:0] page_flags;

  modport source (output valid, req_type, virt_page, phys_addr, page_flags, input ready);
  modport sink (input valid, req_type, virt_page, phys_addr, page_flags, output ready);
endinterface

[sv/ptmu_rsp_if.sv]
// Result channel of the page table map/unmap engine.
// Depends on ptmu_pkg for the field widths.
interface ptmu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptmu_pkg::STATUS_W-1:0] status;
  logic [ptmu_pkg::PHYS_W-1:0]   entry_value;
  logic                          table_created;
  logic                          flush_page;

  modport source (output valid, status, entry_value, table_created, flush_page, input ready);
  modport sink (input valid, status, entry_value, table_created, flush_page, output ready);
endinterface

[sv/ptmu_split.sv]
// Splits a virtual page number into directory and table indices by
// multiplying with constant reciprocals, three registered stages.
// Depends on ptmu_pkg.
module ptmu_split #(
  parameter int DIR_ENTRIES   = 16,
  parameter int TABLE_ENTRIES = 1024,
  parameter int DIR_W         = 4,
  parameter int TIDX_W        = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ptmu_pkg::PAGE_W-1:0] page,
  output logic                        done,
  output logic [DIR_W-1:0]            dir,
  output logic [TIDX_W-1:0]           tidx
);

  localparam int PW  = ptmu_pkg::PAGE_W;
  localparam int T_L = $clog2(TABLE_ENTRIES);
  localparam int D_L = $clog2(DIR_ENTRIES);
  localparam int S1  = PW + T_L;
  localparam int S2  = PW + D_L;
  localparam int M_W = PW + 1;
  localparam int P_W = PW + M_W;
  // Rounded-up reciprocals; exact for every dividend below 2**PAGE_W.
  localparam logic [M_W-1:0] M1  = M_W'(((1 << S1) + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
  localparam logic [M_W-1:0] M2  = M_W'(((1 << S2) + DIR_ENTRIES - 1) / DIR_ENTRIES);
  localparam logic [M_W-1:0] T_K = M_W'(TABLE_ENTRIES);
  localparam logic [M_W-1:0] D_K = M_W'(DIR_ENTRIES);

  logic          v1, v2, v3;
  logic [PW-1:0] q1, q1_d, q2, page_d;
  logic [P_W-1:0] prod1, prod_t, prod2, prod_d;

  assign prod1  = P_W'(page) * P_W'(M1);
  assign prod_t = P_W'(q1) * P_W'(T_K);
  assign prod2  = P_W'(q1) * P_W'(M2);
  assign prod_d = P_W'(q2) * P_W'(D_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q1     <= PW'(prod1 >> S1);
      page_d <= page;
    end
    if (v1) begin
      q1_d <= q1;
      q2   <= PW'(prod2 >> S2);
      tidx <= TIDX_W'(page_d - PW'(prod_t));
    end
    // The directory index is the first quotient taken modulo the directory size.
    if (v2) begin
      dir <= DIR_W'(q1_d - PW'(prod_d));
    end
  end

  assign done = v3;

endmodule

[sv/ptmu_tables.sv]
// Directory present bits and page table entries, each a synchronous
// memory with registered reads. Depends on ptmu_pkg.
module ptmu_tables #(
  parameter int DIR_ENTRIES = 16,
  parameter int DIR_W       = 4,
  parameter int ENT_DEPTH   = 16384,
  parameter int ENT_AW      = 14
) (
  input  logic                        clk,
  input  ptmu_pkg::mem_cmd_t          cmd,
  input  logic [DIR_W-1:0]            dir_addr,
  input  logic [ENT_AW-1:0]           ent_addr,
  input  logic [ptmu_pkg::PHYS_W-1:0] ent_wdata,
  output logic                        dir_q,
  output logic [ptmu_pkg::PHYS_W-1:0] ent_q
);

  logic                        dir_mem [DIR_ENTRIES];
  logic [ptmu_pkg::PHYS_W-1:0] ent_mem [ENT_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.dir_we) begin
      dir_mem[dir_addr] <= cmd.dir_wbit;
    end
    if (cmd.dir_re) begin
      dir_q <= dir_mem[dir_addr];
    end
  end

  // Bit 0 of an entry doubles as the page's mapped bit.
  always_ff @(posedge clk) begin
    if (cmd.ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (cmd.ent_re) begin
      ent_q <= ent_mem[ent_addr];
    end
  end

endmodule

[sv/page_table_map_unmap_top.sv]
// Top level of the page table map/unmap engine: request sequencer, output
// register, index split and table memories. Depends on ptmu_pkg,
// ptmu_req_if, ptmu_rsp_if, ptmu_split and ptmu_tables.

// A map or unmap request runs from acceptance through the index split,
// whose last step also issues the memory read of the directory bit and the
// entry, then a check of the read data, then write-back, which loads the
// result register and writes the entry unless a map is rejected and waits
// while the output register is still full, and back to idle to take the
// next request. A map into an absent directory slot first zeroes the whole
// table through the single entry write port, one entry per cycle. After
// reset the directory memory is cleared, during which no request is taken.
// The page number wraps modulo DIR_ENTRIES * TABLE_ENTRIES. A finished
// result waits in the output register while the next request is processed.
module page_table_map_unmap_top #(
  parameter int DIR_ENTRIES   = 16,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  ptmu_req_if.sink   req,
  ptmu_rsp_if.source rsp
);

  localparam int DIR_W     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int TIDX_W    = $clog2(TABLE_ENTRIES);
  localparam int CNT_W     = (DIR_W > TIDX_W) ? DIR_W : TIDX_W;
  localparam int ENT_DEPTH = DIR_ENTRIES * (1 << TIDX_W);
  localparam int ENT_AW    = $clog2(ENT_DEPTH);

  ptmu_pkg::ctrl_state_t state, state_next;
  ptmu_pkg::mem_cmd_t    cmd;

  logic [CNT_W-1:0]            cnt;
  logic                        last_init, last_clear;
  logic                        in_ready, accept, load, out_free;
  logic                        out_valid;
  logic                        split_done;
  logic [DIR_W-1:0]            split_dir, dir_addr;
  logic [TIDX_W-1:0]           split_tidx, ent_idx;
  logic [ENT_AW-1:0]           ent_addr;
  logic [ptmu_pkg::PHYS_W-1:0] ent_wdata, new_entry, ent_q;
  logic                        dir_q;

  ptmu_pkg::req_kind_t          kind;
  logic [ptmu_pkg::PHYS_W-1:0]  phys;
  logic [ptmu_pkg::FLAGS_W-1:0] flags;
  logic                         hit;
  logic                         created;

  logic [ptmu_pkg::STATUS_W-1:0] out_status;
  logic [ptmu_pkg::PHYS_W-1:0]   out_entry;
  logic                          out_created;
  logic                          out_flush;

  assign accept     = req.valid && in_ready;
  assign out_free   = !out_valid || rsp.ready;
  assign last_init  = (cnt == CNT_W'(DIR_ENTRIES - 1));
  assign last_clear = (cnt == CNT_W'(TABLE_ENTRIES - 1));
  assign new_entry  = phys | ptmu_pkg::PHYS_W'(flags) | ptmu_pkg::ENTRY_PRESENT;

  assign dir_addr  = (state == ptmu_pkg::CS_INIT) ? cnt[DIR_W-1:0] : split_dir;
  assign ent_idx   = (state == ptmu_pkg::CS_CLEAR) ? cnt[TIDX_W-1:0] : split_tidx;
  assign ent_addr  = ENT_AW'({split_dir, ent_idx});
  assign ent_wdata = ((state == ptmu_pkg::CS_CLEAR) || (kind == ptmu_pkg::REQ_UNMAP))
                     ? '0 : new_entry;

  ptmu_split #(
    .DIR_ENTRIES   (DIR_ENTRIES),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .DIR_W         (DIR_W),
    .TIDX_W        (TIDX_W)
  ) u_split (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .page  (req.virt_page),
    .done  (split_done),
    .dir   (split_dir),
    .tidx  (split_tidx)
  );

  ptmu_tables #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .DIR_W       (DIR_W),
    .ENT_DEPTH   (ENT_DEPTH),
    .ENT_AW      (ENT_AW)
  ) u_tables (
    .clk       (clk),
    .cmd       (cmd),
    .dir_addr  (dir_addr),
    .ent_addr  (ent_addr),
    .ent_wdata (ent_wdata),
    .dir_q     (dir_q),
    .ent_q     (ent_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ptmu_pkg::CS_INIT: begin
        if (last_init) state_next = ptmu_pkg::CS_IDLE;
      end
      ptmu_pkg::CS_IDLE: begin
        if (accept) state_next = ptmu_pkg::CS_SPLIT;
      end
      ptmu_pkg::CS_SPLIT: begin
        if (split_done) state_next = ptmu_pkg::CS_CHECK;
      end
      ptmu_pkg::CS_CHECK: begin
        if ((kind == ptmu_pkg::REQ_MAP) && !dir_q) state_next = ptmu_pkg::CS_CLEAR;
        else state_next = ptmu_pkg::CS_DONE;
      end
      ptmu_pkg::CS_CLEAR: begin
        if (last_clear) state_next = ptmu_pkg::CS_DONE;
      end
      ptmu_pkg::CS_DONE: begin
        if (out_free) state_next = ptmu_pkg::CS_IDLE;
      end
      default: state_next = ptmu_pkg::CS_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    load     = 1'b0;
    case (state)
      ptmu_pkg::CS_INIT: begin
        cmd.dir_we = 1'b1;
      end
      ptmu_pkg::CS_IDLE: begin
        in_ready = 1'b1;
      end
      ptmu_pkg::CS_SPLIT: begin
        cmd.dir_re = split_done;
        cmd.ent_re = split_done;
      end
      ptmu_pkg::CS_CLEAR: begin
        cmd.ent_we = 1'b1;
        // The slot turns present together with the last zeroed entry.
        cmd.dir_we   = last_clear;
        cmd.dir_wbit = last_clear;
      end
      ptmu_pkg::CS_DONE: begin
        load       = out_free;
        cmd.ent_we = out_free && !((kind == ptmu_pkg::REQ_MAP) && hit);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptmu_pkg::CS_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !rsp.ready);
      if (state == ptmu_pkg::CS_INIT) begin
        cnt <= last_init ? '0 : cnt + CNT_W'(1);
      end else if (state == ptmu_pkg::CS_CHECK) begin
        cnt <= '0;
      end else if (state == ptmu_pkg::CS_CLEAR) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind    <= ptmu_pkg::req_kind_t'(req.req_type);
      phys    <= req.phys_addr;
      flags   <= req.page_flags;
      created <= 1'b0;
    end
    if (state == ptmu_pkg::CS_CHECK) begin
      hit <= (kind == ptmu_pkg::REQ_MAP) && dir_q && ent_q[0];
      if ((kind == ptmu_pkg::REQ_MAP) && !dir_q) created <= 1'b1;
    end
    if (load) begin
      out_created <= created;
      if (kind == ptmu_pkg::REQ_UNMAP) begin
        out_status <= ptmu_pkg::ST_UNMAPPED;
        out_entry  <= '0;
        out_flush  <= 1'b1;
      end else if (hit) begin
        out_status <= ptmu_pkg::ST_REJECTED;
        out_entry  <= '0;
        out_flush  <= 1'b0;
      end else begin
        out_status <= ptmu_pkg::ST_MAPPED;
        out_entry  <= new_entry;
        out_flush  <= 1'b1;
      end
    end
  end

  assign req.ready         = in_ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.entry_value   = out_entry;
  assign rsp.table_created = out_created;
  assign rsp.flush_page    = out_flush;

`ifndef SYNTHESIS
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !$past(rsp.valid)) |-> $past(state == ptmu_pkg::CS_DONE))
    else $error("result register loaded outside the write-back state");

  a_split_latency: assert property (@(posedge clk) disable iff (rst)
    split_done |-> $past(accept, 3))
    else $error("index split finished at the wrong cycle");

  a_reject_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ptmu_pkg::CS_DONE && kind == ptmu_pkg::REQ_MAP && hit) |-> !cmd.ent_we)
    else $error("entry written on a rejected map");

  a_dir_set_end_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.dir_we && cmd.dir_wbit) |-> (state == ptmu_pkg::CS_CLEAR && last_clear))
    else $error("directory slot marked present before its table was cleared");

  a_reject_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ptmu_pkg::ST_REJECTED)
      |-> (!rsp.flush_page && rsp.entry_value == '0))
    else $error("rejected map reported a flush or an entry value");
`endif

endmodule
